@@ sv/btff_pkg.sv @@
// Package for the boundary-tag first-fit allocator.
// Holds widths, tag and link constants shared by the allocator modules.
// No dependencies.
`default_nettype none
package btff_pkg;
   localparam int unsigned HeapUnitsDefault   = 4096;
   localparam int unsigned HeaderUnitsDefault = 24;
   localparam int unsigned TagUnitsDefault    = 4;
   localparam int unsigned MinHeap            = 64;
   localparam int unsigned CfgWidth           = 13;
   localparam int unsigned ReqWidth           = 13;
   localparam int unsigned AddrWidth          = 12;
   localparam logic [CfgWidth-1:0] HeapSizeReset = 13'd256;
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;
   localparam logic ST_OK    = 1'b0;
   localparam logic ST_NOFIT = 1'b1;
endpackage
`default_nettype wire

@@ sv/boundary_tag_first_fit_allocator.sv @@
// Top level of the boundary-tag first-fit heap allocator.
// Depends on btff_pkg and btff_ram (tag and link stores).
//
// Usage: pulse start with req_operation, req_request_size and
// req_block_address while busy is low; the beat is taken on that edge and
// busy rises until the one result beat appears. The result shows on
// rsp_result_address and rsp_status for exactly one cycle, marked by
// rsp_strobe; the receiver cannot hold it off, so busy falls in the same
// cycle and a new item may start at the next edge.
// The heap_size register is written through csr_valid/csr_ready while idle;
// a write forces the heap to be rebuilt on the next allocate.
// Operation: each store has one port with registered read data. An allocate
// walks the free list first fit, reading each block visited through
// S_WALK_RD, S_WALK_W and S_WALK_CHK, then updates tags and links, or
// closes at once when nothing fits; the allocate that builds the heap first
// passes S_BUILD1 and S_BUILD2. A free ends at once when it is ignored and
// otherwise checks its neighbours for merges before it pushes the block.
// Reset: synchronous and active high; it empties the list, clears the
// built flag and loads heap_size 256. The stores get no clearing pass, so
// a free can read a tag that was never written.
`default_nettype none
module boundary_tag_first_fit_allocator #(
   parameter int unsigned HeapUnits   = btff_pkg::HeapUnitsDefault,
   parameter int unsigned HeaderUnits = btff_pkg::HeaderUnitsDefault,
   parameter int unsigned TagUnits    = btff_pkg::TagUnitsDefault
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   output logic                                busy,
   input  wire logic                           req_operation,
   input  wire logic [btff_pkg::ReqWidth-1:0]  req_request_size,
   input  wire logic [btff_pkg::AddrWidth-1:0] req_block_address,
   output logic                                rsp_strobe,
   output logic [btff_pkg::AddrWidth-1:0]      rsp_result_address,
   output logic                                rsp_status,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [btff_pkg::CfgWidth-1:0]  csr_heap_size
);
   import btff_pkg::*;

   // Addresses are one bit wider than the store index so the null link
   // (HeapUnits) fits.
   localparam int unsigned IW = $clog2(HeapUnits);
   localparam int unsigned AW = IW + 1;
   localparam int unsigned SW = AW + 1;
   localparam logic [AW-1:0] NIL = AW'(HeapUnits);
   localparam logic [AW-1:0] HDR = AW'(HeaderUnits);
   localparam logic [AW-1:0] TGU = AW'(TagUnits);
   localparam logic [AW-1:0] OFF = AW'(HeaderUnits - TagUnits);
   localparam int unsigned TW = AW + 1;   // size plus free flag
   localparam int unsigned LW = 2 * AW;   // prev, next

   typedef enum logic [5:0] {
      S_IDLE, S_BUILD1, S_BUILD2, S_WALK_RD, S_WALK_W, S_WALK_CHK,
      S_LNK_RD, S_LNK_W, S_SPL_T1, S_SPL_T2, S_SPL_L, S_FIX_P, S_FIX_PR,
      S_FIX_PW, S_FIX_N, S_FIX_NR, S_FIX_NW, S_HEAD, S_OWN_T1, S_OWN_T2,
      S_F_RD, S_F_W, S_F_CHK, S_FP_RD, S_FP_W, S_FP_CHK, S_FP2_RD, S_FP2_W,
      S_FP2_CHK, S_FN_RD, S_FN_W, S_FN_CHK, S_PUT1, S_PUT2, S_PUSH,
      S_PH_RD, S_PH_W, S_PH_WR, S_DONE
   } state_type;

   // Unlink sub-sequence returns to one of these.
   typedef enum logic [1:0] {R_ALLOC, R_FREEP, R_FREEN} ret_type;

   state_type state_ff;
   ret_type ret_ff;
   logic [AW-1:0] head_ff, cur_ff, need_ff, sz_ff, nx_ff, pv_ff, start_ff;
   logic [AW-1:0] size_ff, eff_ff, tmp_ff;
   logic [AW:0] steps_ff;
   logic ready_ff, split_ff;
   logic [CfgWidth-1:0] hsize_ff;
   logic [ReqWidth-1:0] reqsz_ff;

   // Store ports.
   logic t_we, l_we;
   logic [IW-1:0] t_a, l_a;
   logic [TW-1:0] t_wd, t_rd;
   logic [LW-1:0] l_wd, l_rd;
   logic [AW-1:0] ta_full, la_full;
   logic t_ok, l_ok;

   assign t_ok = (ta_full < NIL);
   assign l_ok = (la_full < NIL);
   assign t_a  = ta_full[IW-1:0];
   assign l_a  = la_full[IW-1:0];

   btff_ram #(.Width(TW), .Depth(HeapUnits)) u_tag (
      .clock(clock), .wr_en(t_we & t_ok), .addr(t_a), .wr_data(t_wd), .rd_data(t_rd));
   btff_ram #(.Width(LW), .Depth(HeapUnits)) u_link (
      .clock(clock), .wr_en(l_we & l_ok), .addr(l_a), .wr_data(l_wd), .rd_data(l_rd));

   // Reads outside the store answer zero for tags and null for links.
   logic t_ok_ff, l_ok_ff;
   logic [AW-1:0] rd_size, rd_next, rd_prev;
   logic rd_free;
   assign rd_size = t_ok_ff ? t_rd[AW-1:0] : '0;
   assign rd_free = t_ok_ff ? t_rd[AW] : 1'b0;
   assign rd_next = l_ok_ff ? l_rd[AW-1:0] : NIL;
   assign rd_prev = l_ok_ff ? l_rd[LW-1:AW] : NIL;

   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = (state_ff == S_IDLE) & ~start;

   // The walk ends without a fit at a null or out-of-heap link, or at the
   // step bound. A result beat follows the last state of every item.
   logic walk_end, rsp_fire;
   assign walk_end = (cur_ff == NIL) || (cur_ff >= eff_ff) ||
                     (steps_ff == (AW+1)'(HeapUnits));
   assign rsp_fire = (state_ff == S_WALK_RD && walk_end) ||
                     (state_ff == S_OWN_T2) || (state_ff == S_DONE);

   // Saturated heap size.
   logic [AW-1:0] eff_now;
   always_comb begin
      if (hsize_ff < CfgWidth'(MinHeap)) begin
         eff_now = AW'(MinHeap);
      end else if (SW'(hsize_ff) > SW'(HeapUnits)) begin
         eff_now = NIL;
      end else begin
         eff_now = AW'(hsize_ff);
      end
   end

   // Combinational store commands per state. A read address is held through
   // the wait state so the registered data belongs to it.
   always_comb begin
      t_we = 1'b0; l_we = 1'b0;
      ta_full = cur_ff; la_full = cur_ff;
      t_wd = '0; l_wd = '0;
      unique case (state_ff)
         S_BUILD1: begin
            t_we = 1'b1; ta_full = '0; t_wd = {1'b1, eff_ff};
            l_we = 1'b1; la_full = '0; l_wd = {NIL, NIL};
         end
         S_BUILD2: begin
            t_we = 1'b1; ta_full = eff_ff - TGU; t_wd = {1'b1, eff_ff};
         end
         S_WALK_RD, S_LNK_RD: begin
            ta_full = cur_ff; la_full = cur_ff;
         end
         S_SPL_T1: begin
            t_we = 1'b1; ta_full = cur_ff + need_ff; t_wd = {1'b1, sz_ff - need_ff};
            l_we = 1'b1; la_full = cur_ff + need_ff; l_wd = {pv_ff, nx_ff};
         end
         S_SPL_T2: begin
            if (sz_ff - need_ff >= TGU) t_we = 1'b1;
            ta_full = cur_ff + sz_ff - TGU; t_wd = {1'b1, sz_ff - need_ff};
         end
         S_FIX_PR: la_full = pv_ff;
         S_FIX_PW: begin
            l_we = 1'b1; la_full = pv_ff; l_wd = {rd_prev, tmp_ff};
         end
         S_FIX_NR: la_full = nx_ff;
         S_FIX_NW: begin
            l_we = 1'b1; la_full = nx_ff; l_wd = {tmp_ff, rd_next};
         end
         S_OWN_T1: begin
            t_we = 1'b1; ta_full = cur_ff; t_wd = {1'b0, need_ff};
         end
         S_OWN_T2: begin
            if (need_ff >= TGU) t_we = 1'b1;
            ta_full = cur_ff + need_ff - TGU; t_wd = {1'b0, need_ff};
         end
         S_F_RD, S_F_W: ta_full = start_ff;
         S_FP_RD, S_FP_W: ta_full = start_ff - TGU;
         S_FP2_RD, S_FP2_W: ta_full = start_ff - tmp_ff;
         S_FN_RD, S_FN_W: ta_full = start_ff + size_ff;
         S_PUT1: begin
            t_we = 1'b1; ta_full = start_ff; t_wd = {1'b1, size_ff};
            l_we = 1'b1; la_full = start_ff; l_wd = {NIL, head_ff};
         end
         S_PUT2: begin
            if (size_ff >= TGU) t_we = 1'b1;
            ta_full = start_ff + size_ff - TGU; t_wd = {1'b1, size_ff};
         end
         S_PH_RD, S_PH_W: la_full = head_ff;
         S_PH_WR: begin
            l_we = 1'b1; la_full = head_ff; l_wd = {start_ff, rd_next};
         end
         default: ;
      endcase
   end

   // Sequencer: state, registers and registered outputs.
   always_ff @(posedge clock) begin
      t_ok_ff <= t_ok;
      l_ok_ff <= l_ok;
      if (reset) begin
         state_ff <= S_IDLE;
         ret_ff <= R_ALLOC;
         head_ff <= NIL;
         ready_ff <= 1'b0;
         hsize_ff <= HeapSizeReset;
         rsp_strobe <= 1'b0;
         rsp_result_address <= '0;
         rsp_status <= ST_OK;
      end else begin
         rsp_strobe <= rsp_fire;
         unique case (state_ff)
            S_IDLE: begin
               if (csr_valid && csr_ready) begin
                  hsize_ff <= csr_heap_size;
                  ready_ff <= 1'b0;
                  head_ff <= NIL;
               end
               if (start) begin
                  eff_ff <= eff_now;
                  reqsz_ff <= req_request_size;
                  start_ff <= AW'(req_block_address) - OFF;
                  steps_ff <= '0;
                  if (req_operation == OP_ALLOC) begin
                     need_ff <= AW'(req_request_size) + HDR;
                     state_ff <= ready_ff ? S_WALK_RD : S_BUILD1;
                     cur_ff <= ready_ff ? head_ff : '0;
                  end else if (!ready_ff || AW'(req_block_address) < OFF ||
                               AW'(req_block_address) - OFF >= eff_now) begin
                     state_ff <= S_DONE;
                  end else begin
                     state_ff <= S_F_RD;
                  end
               end
            end
            S_BUILD1: state_ff <= S_BUILD2;
            S_BUILD2: begin
               head_ff <= '0; cur_ff <= '0; ready_ff <= 1'b1;
               state_ff <= S_WALK_RD;
            end
            S_WALK_RD: begin
               if (walk_end) begin
                  rsp_result_address <= '0; rsp_status <= ST_NOFIT;
                  state_ff <= S_IDLE;
               end else begin
                  state_ff <= S_WALK_W;
               end
            end
            S_WALK_W: state_ff <= S_WALK_CHK;
            S_WALK_CHK: begin
               // Wide compare: request plus header may exceed the address range.
               if ((SW'(reqsz_ff) + SW'(HeaderUnits)) <= SW'(rd_size)) begin
                  sz_ff <= rd_size; nx_ff <= rd_next; pv_ff <= rd_prev;
                  split_ff <= (rd_size - need_ff) > HDR;
                  ret_ff <= R_ALLOC;
                  if ((rd_size - need_ff) > HDR) begin
                     state_ff <= S_SPL_T1;
                  end else begin
                     need_ff <= rd_size;
                     tmp_ff <= rd_next;       // unlink: neighbors get next/prev
                     state_ff <= S_FIX_P;
                  end
               end else begin
                  cur_ff <= rd_next; steps_ff <= steps_ff + 1'b1;
                  state_ff <= S_WALK_RD;
               end
            end
            S_SPL_T1: state_ff <= S_SPL_T2;
            S_SPL_T2: begin
               tmp_ff <= cur_ff + need_ff;
               state_ff <= S_FIX_P;
            end
            // Neighbor fix-up, shared by split and unlink. tmp_ff holds the
            // value for prev.next; for the next block's prev, split uses the
            // remainder and unlink uses pv.
            S_FIX_P: state_ff <= (pv_ff != NIL) ? S_FIX_PR : S_FIX_N;
            S_FIX_PR: state_ff <= S_FIX_PW;
            S_FIX_PW: state_ff <= S_FIX_N;
            S_FIX_N: begin
               if (!split_ff || ret_ff != R_ALLOC) tmp_ff <= pv_ff;
               state_ff <= (nx_ff != NIL) ? S_FIX_NR : S_HEAD;
            end
            S_FIX_NR: state_ff <= S_FIX_NW;
            S_FIX_NW: state_ff <= S_HEAD;
            S_HEAD: begin
               if (head_ff == cur_ff) begin
                  head_ff <= (split_ff && ret_ff == R_ALLOC) ? cur_ff + need_ff : nx_ff;
               end
               unique case (ret_ff)
                  R_ALLOC: state_ff <= S_OWN_T1;
                  R_FREEP: begin
                     start_ff <= cur_ff; size_ff <= size_ff + sz_ff;
                     state_ff <= S_FN_RD;
                  end
                  default: begin
                     size_ff <= size_ff + sz_ff;
                     state_ff <= S_PUT1;
                  end
               endcase
            end
            S_OWN_T1: state_ff <= S_OWN_T2;
            S_OWN_T2: begin
               rsp_result_address <= AddrWidth'(cur_ff + OFF);
               rsp_status <= ST_OK;
               state_ff <= S_IDLE;
            end
            S_F_RD: state_ff <= S_F_W;
            S_F_W: state_ff <= S_F_CHK;
            S_F_CHK: begin
               size_ff <= rd_size;
               if (rd_free || rd_size < HDR || SW'(start_ff) + SW'(rd_size) > SW'(eff_ff)) begin
                  state_ff <= S_DONE;
               end else begin
                  state_ff <= (start_ff >= TGU) ? S_FP_RD : S_FN_RD;
               end
            end
            S_FP_RD: state_ff <= S_FP_W;
            S_FP_W: state_ff <= S_FP_CHK;
            S_FP_CHK: begin
               tmp_ff <= rd_size;
               state_ff <= (rd_size >= HDR && rd_size <= start_ff) ? S_FP2_RD : S_FN_RD;
            end
            S_FP2_RD: state_ff <= S_FP2_W;
            S_FP2_W: state_ff <= S_FP2_CHK;
            S_FP2_CHK: begin
               if (rd_free && rd_size == tmp_ff) begin
                  cur_ff <= start_ff - tmp_ff; sz_ff <= tmp_ff;
                  ret_ff <= R_FREEP; split_ff <= 1'b0;
                  state_ff <= S_LNK_RD;
               end else begin
                  state_ff <= S_FN_RD;
               end
            end
            S_FN_RD: begin
               state_ff <= (start_ff + size_ff < eff_ff) ? S_FN_W : S_PUT1;
            end
            S_FN_W: state_ff <= S_FN_CHK;
            S_FN_CHK: begin
               if (rd_free && rd_size >= HDR &&
                   SW'(start_ff) + SW'(size_ff) + SW'(rd_size) <= SW'(eff_ff)) begin
                  cur_ff <= start_ff + size_ff; sz_ff <= rd_size;
                  ret_ff <= R_FREEN; split_ff <= 1'b0;
                  state_ff <= S_LNK_RD;
               end else begin
                  state_ff <= S_PUT1;
               end
            end
            S_LNK_RD: state_ff <= S_LNK_W;
            S_LNK_W: begin
               nx_ff <= rd_next; pv_ff <= rd_prev; tmp_ff <= rd_next;
               state_ff <= S_FIX_P;
            end
            S_PUT1: state_ff <= S_PUT2;
            S_PUT2: state_ff <= (head_ff != NIL) ? S_PH_RD : S_PUSH;
            S_PH_RD: state_ff <= S_PH_W;
            S_PH_W: state_ff <= S_PH_WR;
            S_PH_WR: state_ff <= S_PUSH;
            S_PUSH: begin
               head_ff <= start_ff;
               state_ff <= S_DONE;
            end
            S_DONE: begin
               rsp_result_address <= '0; rsp_status <= ST_OK;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // The walk never runs past the step bound.
   a_steps: assert property (@(posedge clock) disable iff (reset)
      steps_ff <= (AW+1)'(HeapUnits)) else $error("walk step bound exceeded");
   // A result beat always ends the busy period.
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !$past(reset) && state_ff == S_IDLE) else $error("strobe while busy");
   // The configuration register only moves while idle.
   a_cfg_idle: assert property (@(posedge clock) disable iff (reset)
      busy |=> $stable(hsize_ff)) else $error("heap size changed during work");
endmodule
`default_nettype wire

@@ sv/btff_ram.sv @@
// Generic single-port RAM with registered read data.
// Parameters set the width and depth; no package dependency.
`default_nettype none
module btff_ram #(
   parameter int unsigned Width = 8,
   parameter int unsigned Depth = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] addr,
   input  wire logic [Width-1:0]         wr_data,
   output logic      [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule
`default_nettype wire

@@ verif/boundary_tag_first_fit_allocator_tb.sv @@
// Self-checking testbench for the boundary-tag first-fit heap allocator.
// Depends on btff_pkg and the boundary_tag_first_fit_allocator RTL only.
`timescale 1ns / 100ps
`default_nettype none
module boundary_tag_first_fit_allocator_tb;
   import btff_pkg::*;

   localparam int unsigned Units     = 4096;
   localparam int unsigned Header    = 24;
   localparam int unsigned Tag       = 4;
   localparam int unsigned UserOff   = Header - Tag;
   localparam int unsigned NilLink   = Units;
   localparam int unsigned StallLimit = 20000;

   typedef struct packed {
      logic [AddrWidth-1:0] address;
      logic                 status;
   } alloc_result_type;

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic                 req_operation;
   logic [ReqWidth-1:0]  req_request_size;
   logic [AddrWidth-1:0] req_block_address;
   logic                 rsp_strobe;
   logic [AddrWidth-1:0] rsp_result_address;
   logic                 rsp_status;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CfgWidth-1:0]  csr_heap_size;

   boundary_tag_first_fit_allocator i_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_operation      (req_operation),
      .req_request_size   (req_request_size),
      .req_block_address  (req_block_address),
      .rsp_strobe         (rsp_strobe),
      .rsp_result_address (rsp_result_address),
      .rsp_status         (rsp_status),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_heap_size      (csr_heap_size)
   );

   // Shadow copy of the heap: boundary tags, list links, list head and the
   // built flag, updated in the order the block accepts its beats.
   int unsigned   blk_size [Units];
   bit            blk_free [Units];
   int unsigned   link_next [Units];
   int unsigned   link_prev [Units];
   int unsigned   list_head;
   bit            heap_built;
   int unsigned   heap_cfg;

   // Results still owed by the block, oldest first.
   alloc_result_type pending_results[$];
   // User addresses handed out, and addresses freed, since the heap was built.
   int unsigned   live_blocks[$];
   int unsigned   freed_blocks[$];

   int unsigned   mismatches;
   int unsigned   quiet_cycles;
   int unsigned   burst_left;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int unsigned heap_limit();
      if (heap_cfg < MinHeap) return MinHeap;
      if (heap_cfg > Units) return Units;
      return heap_cfg;
   endfunction

   // Header at p, footer at the last tag of the block; writes past the store
   // are dropped just as the hardware drops them.
   function automatic void write_tags(int unsigned p, int unsigned size, bit is_free);
      if (p < Units) begin
         blk_size[p] = size;
         blk_free[p] = is_free;
      end
      if (size >= Tag && p + size - Tag < Units) begin
         blk_size[p + size - Tag] = size;
         blk_free[p + size - Tag] = is_free;
      end
   endfunction

   function automatic int unsigned size_at(int unsigned a);
      return (a < Units) ? blk_size[a] : 0;
   endfunction

   function automatic void set_next(int unsigned a, int unsigned n);
      if (a < Units) link_next[a] = n;
   endfunction

   function automatic void set_prev(int unsigned a, int unsigned p);
      if (a < Units) link_prev[a] = p;
   endfunction

   function automatic void drop_from_list(int unsigned n);
      int unsigned nx;
      int unsigned pv;
      nx = (n < Units) ? link_next[n] : NilLink;
      pv = (n < Units) ? link_prev[n] : NilLink;
      if (pv != NilLink) set_next(pv, nx);
      if (nx != NilLink) set_prev(nx, pv);
      if (list_head == n) list_head = nx;
   endfunction

   // First-fit allocate: walk the list, split when the remainder is larger
   // than the header overhead, otherwise hand out the whole block.
   function automatic alloc_result_type place_block(int unsigned req);
      alloc_result_type res;
      int unsigned   lim;
      int unsigned   need;
      int unsigned   cur;
      int unsigned   sz;
      int unsigned   rem;
      int unsigned   nx;
      int unsigned   pv;
      bit            hit;
      lim  = heap_limit();
      need = req + Header;
      hit  = 1'b0;
      if (!heap_built) begin
         write_tags(0, lim, 1'b1);
         link_next[0] = NilLink;
         link_prev[0] = NilLink;
         list_head  = 0;
         heap_built = 1'b1;
      end
      cur = list_head;
      for (int unsigned steps = 0; steps < Units; steps++) begin
         if (cur == NilLink || cur >= lim) break;
         if (size_at(cur) >= need) begin
            hit = 1'b1;
            break;
         end
         cur = (cur < Units) ? link_next[cur] : NilLink;
      end
      if (!hit) begin
         res.address = '0;
         res.status  = ST_NOFIT;
         return res;
      end
      sz = size_at(cur);
      if (sz - need > Header) begin
         rem = cur + need;
         nx  = link_next[cur];
         pv  = link_prev[cur];
         write_tags(rem, sz - need, 1'b1);
         set_next(rem, nx);
         set_prev(rem, pv);
         if (pv != NilLink) set_next(pv, rem);
         if (nx != NilLink) set_prev(nx, rem);
         if (list_head == cur) list_head = rem;
      end else begin
         need = sz;
         drop_from_list(cur);
      end
      write_tags(cur, need, 1'b0);
      res.address = AddrWidth'(cur + UserOff);
      res.status  = ST_OK;
      return res;
   endfunction

   // Free with coalescing on both sides; bad or early frees change nothing.
   function automatic void release_block(int unsigned addr);
      int unsigned lim;
      int unsigned base;
      int unsigned size;
      int unsigned ps;
      int unsigned p;
      int unsigned ns;
      lim = heap_limit();
      if (!heap_built || addr < UserOff) return;
      base = addr - UserOff;
      if (base >= lim) return;
      size = size_at(base);
      if (blk_free[base] || size < Header || base + size > lim) return;
      if (base >= Tag) begin
         ps = size_at(base - Tag);
         if (ps >= Header && ps <= base) begin
            p = base - ps;
            if (blk_free[p] && size_at(p) == ps) begin
               drop_from_list(p);
               base = p;
               size += ps;
            end
         end
      end
      p = base + size;
      if (p < lim) begin
         ns = size_at(p);
         if (blk_free[p] && ns >= Header && p + ns <= lim) begin
            drop_from_list(p);
            size += ns;
         end
      end
      write_tags(base, size, 1'b1);
      link_next[base] = list_head;
      link_prev[base] = NilLink;
      if (list_head != NilLink) set_prev(list_head, base);
      list_head = base;
   endfunction

   // Sends one item in the current burst, or opens a new burst after a
   // random gap. Entered and left just after a falling edge.
   task automatic send_item(logic op, int unsigned req, int unsigned addr);
      alloc_result_type res;
      bit            taken;
      if (burst_left == 0) begin
         start = 1'b0;
         repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12)) @(negedge clock);
         burst_left = $urandom_range(1, 30);
      end
      burst_left--;
      start             = 1'b1;
      req_operation     = op;
      req_request_size  = ReqWidth'(req);
      req_block_address = AddrWidth'(addr);
      taken = 1'b0;
      while (!taken) begin
         @(posedge clock);
         taken = !busy;
      end
      if (op == OP_ALLOC) begin
         res = place_block(req);
         if (res.status == ST_OK) live_blocks.push_back(res.address);
      end else begin
         release_block(addr);
         res.address = '0;
         res.status  = ST_OK;
      end
      pending_results.push_back(res);
      @(negedge clock);
      start = 1'b0;
   endtask

   task automatic drain_results();
      while (pending_results.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Register write between phases; the heap is rebuilt on the next allocate.
   task automatic write_heap_size(int unsigned value);
      bit taken;
      drain_results();
      csr_valid     = 1'b1;
      csr_heap_size = CfgWidth'(value);
      taken = 1'b0;
      while (!taken) begin
         @(posedge clock);
         taken = csr_ready;
      end
      heap_cfg   = value;
      heap_built = 1'b0;
      list_head  = NilLink;
      live_blocks.delete();
      freed_blocks.delete();
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic free_live(int unsigned idx);
      int unsigned addr;
      addr = live_blocks[idx];
      live_blocks.delete(idx);
      freed_blocks.push_back(addr);
      send_item(OP_FREE, $urandom_range(0, 8191), addr);
   endtask

   // Directed part in the reset configuration: early free, both fits,
   // splits, whole-block takes, bad addresses, every merge and a double free.
   task automatic test_directed();
      int unsigned a;
      int unsigned b;
      int unsigned c;
      int unsigned d;
      send_item(OP_FREE, 0, 100);
      send_item(OP_FREE, 0, 4095);
      send_item(OP_ALLOC, 0, 0);
      a = live_blocks[$];
      send_item(OP_ALLOC, 8191, 0);
      send_item(OP_ALLOC, 4096, 0);
      send_item(OP_ALLOC, 10, 0);
      b = live_blocks[$];
      send_item(OP_ALLOC, 10, 0);
      c = live_blocks[$];
      send_item(OP_ALLOC, 10, 0);
      d = live_blocks[$];
      live_blocks.delete();
      send_item(OP_FREE, 0, 5);
      send_item(OP_FREE, 0, 19);
      send_item(OP_FREE, 0, 4095);
      send_item(OP_FREE, 0, c);
      send_item(OP_FREE, 0, b);
      send_item(OP_FREE, 0, d);
      // b now heads the merged free block, so freeing it again is ignored.
      send_item(OP_FREE, 0, b);
      // Leave a remainder too small to split so the whole block goes out.
      send_item(OP_ALLOC, size_at(list_head) - Header - 10, 0);
      send_item(OP_ALLOC, 0, 0);
      send_item(OP_FREE, 0, a);
      send_item(OP_ALLOC, 0, 0);
      live_blocks.delete();
   endtask

   // Random traffic at one heap size: mostly allocate and free of live
   // blocks, with some double frees, bad addresses and oversize requests.
   task automatic test_random_phase(int unsigned size_value, int unsigned count);
      int unsigned pick;
      int unsigned lim;
      int unsigned addr;
      int unsigned idx;
      write_heap_size(size_value);
      lim = heap_limit();
      // Before the first allocate any free is ignored, whatever the address.
      repeat (3) send_item(OP_FREE, $urandom_range(0, 8191), $urandom_range(0, 4095));
      repeat (count) begin
         pick = $urandom_range(0, 99);
         if (pick >= 45 && pick < 85 && live_blocks.size() != 0) begin
            free_live($urandom_range(0, live_blocks.size() - 1));
         end else if (pick >= 85 && pick < 92 && freed_blocks.size() != 0 &&
                      blk_free[freed_blocks[0] - UserOff]) begin
            idx = $urandom_range(0, freed_blocks.size() - 1);
            addr = freed_blocks[idx];
            if (blk_free[addr - UserOff]) send_item(OP_FREE, 0, addr);
            else send_item(OP_FREE, 0, $urandom_range(0, UserOff - 1));
         end else if (pick >= 92) begin
            if (lim + UserOff <= 4095 && $urandom_range(0, 1) == 1)
               addr = $urandom_range(lim + UserOff, 4095);
            else
               addr = $urandom_range(0, UserOff - 1);
            send_item(OP_FREE, $urandom_range(0, 8191), addr);
         end else if ($urandom_range(0, 19) == 0) begin
            send_item(OP_ALLOC, $urandom_range(0, 8191), $urandom_range(0, 4095));
         end else begin
            send_item(OP_ALLOC, $urandom_range(0, lim / 8), $urandom_range(0, 4095));
         end
      end
   endtask

   // Each result beat is checked against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result beat: address %0d status %0d",
                        rsp_result_address, rsp_status);
         end else begin
            if (rsp_result_address !== pending_results[0].address ||
                rsp_status !== pending_results[0].status) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result mismatch: expected address %0d status %0d, got %0d %0d",
                           pending_results[0].address, pending_results[0].status,
                           rsp_result_address, rsp_status);
            end
            void'(pending_results.pop_front());
         end
      end
   end

   // Watchdog: any accepted beat on any channel counts as progress.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == StallLimit) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      reset             = 1'b1;
      start             = 1'b0;
      req_operation     = OP_ALLOC;
      req_request_size  = '0;
      req_block_address = '0;
      csr_valid         = 1'b0;
      csr_heap_size     = HeapSizeReset;
      heap_cfg          = HeapSizeReset;
      heap_built        = 1'b0;
      list_head         = NilLink;
      mismatches        = 0;
      quiet_cycles      = 0;
      burst_left        = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_random_phase(4096, 560);
      test_random_phase(64, 80);
      test_random_phase(8191, 140);
      test_random_phase(1000, 110);
      test_random_phase(0, 50);
      test_random_phase(130, 60);

      drain_results();
      repeat (60) @(negedge clock);
      if (mismatches == 0 && pending_results.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end
endmodule
`default_nettype wire
